### rtl/radial_falloff_texel_generator_core_defines.svh
// Assertion macros for the radial falloff texel generator checker
`ifndef RADIAL_FALLOFF_TEXEL_GENERATOR_CORE_DEFINES_SVH
`define RADIAL_FALLOFF_TEXEL_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RFG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define RFG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rfg_pkg.sv
// Types, register indexes and the square-root step for the texel generator
package rfg_pkg;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_RADIUS = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam int SQRT_STAGES = 8;
  localparam int DIV_STAGES  = 4;

  // tag travelling beside the root pipeline
  typedef struct packed {
    logic        valid;
    logic        in_disc;
    logic [15:0] d2;
  } rfg_tag_t;

  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
  } rfg_sqrt_t;

  // one digit of the restoring square root: two radicand bits in, one root bit out
  function automatic rfg_sqrt_t sqrt_iter(rfg_sqrt_t cur, logic [1:0] two);
    logic [19:0] r;
    logic [19:0] trial;
    rfg_sqrt_t   res;
    r     = {cur.rem, two};
    trial = {2'b00, cur.root, 2'b01};
    if (r >= trial) begin
      r        = r - trial;
      res.root = {cur.root[14:0], 1'b1};
    end else begin
      res.root = {cur.root[14:0], 1'b0};
    end
    res.rem = r[17:0];
    return res;
  endfunction

endpackage

### rtl/rfg_sqrt_pipe.sv
// Pipelined integer square root of d2*65536, two root bits per stage
module rfg_sqrt_pipe
  import rfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  rfg_tag_t    tag_i,
  output rfg_tag_t    tag_o,
  output logic [15:0] root_o
);

  rfg_tag_t  tag_s [0:SQRT_STAGES];
  rfg_sqrt_t val_s [0:SQRT_STAGES];

  assign tag_s[0] = tag_i;
  assign val_s[0] = '0;

  genvar k;
  generate
    for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
      rfg_tag_t  tag_r;
      rfg_sqrt_t val_r;
      rfg_sqrt_t val_nxt;
      logic [1:0] hi_bits;
      logic [1:0] lo_bits;

      // radicand is d2 followed by 16 zero bits
      if (k < SQRT_STAGES / 2) begin : g_bits
        assign hi_bits = tag_s[k].d2[15-4*k -: 2];
        assign lo_bits = tag_s[k].d2[13-4*k -: 2];
      end else begin : g_zero
        assign hi_bits = 2'b00;
        assign lo_bits = 2'b00;
      end

      always_comb begin
        val_nxt = sqrt_iter(sqrt_iter(val_s[k], hi_bits), lo_bits);
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r.valid <= 1'b0;
        end else if (adv) begin
          tag_r.valid <= tag_s[k].valid;
        end
        if (adv) begin
          tag_r.in_disc <= tag_s[k].in_disc;
          tag_r.d2      <= tag_s[k].d2;
          val_r         <= val_nxt;
        end
      end

      assign tag_s[k+1] = tag_r;
      assign val_s[k+1] = val_r;
    end
  endgenerate

  assign tag_o  = tag_s[SQRT_STAGES];
  assign root_o = val_s[SQRT_STAGES].root;

endmodule

### rtl/radial_falloff_texel_generator_core.sv
// Top level of the radial falloff texel generator
//
//  channel | ports            | word
//  --------+------------------+---------------------------------
//  in      | in_t*            | pixel_x [11:0], pixel_y [23:12]
//  out     | out_t*           | texel [31:0]
//  cfg     | cfg_p* (APB)     | mode, radius, width, height
//
// One word per clock sustained while out_tready holds; words pass through the
// root and quotient pipelines. All stages advance together when the output
// register is empty or being taken. Reset clears valid bits and loads register
// defaults; a stall freezes every stage.
module radial_falloff_texel_generator_core
  import rfg_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_x [11:0], pixel_y [23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // texel [31:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic        mode_r;
  logic [7:0]  radius_r;
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  reg_idx;

  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      radius_r <= 8'd64;
      width_r  <= 13'd256;
      height_r <= 13'd256;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_idx)
        REG_MODE:   mode_r   <= cfg_pwdata[0];
        REG_RADIUS: radius_r <= cfg_pwdata[7:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[12:0];
        REG_HEIGHT: height_r <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:   cfg_prdata = {31'd0, mode_r};
      REG_RADIUS: cfg_prdata = {24'd0, radius_r};
      REG_WIDTH:  cfg_prdata = {19'd0, width_r};
      REG_HEIGHT: cfg_prdata = {19'd0, height_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // centers, with oversized dimensions clamped
  logic [11:0] cx;
  logic [11:0] cy;
  logic [15:0] ss;
  assign cx = (32'(width_r) > MAX_DIM) ? 12'(MAX_DIM / 2) : width_r[12:1];
  assign cy = (32'(height_r) > MAX_DIM) ? 12'(MAX_DIM / 2) : height_r[12:1];
  assign ss = 16'(radius_r) * 16'(radius_r);

  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // stage 1: absolute offsets
  logic        v1_r;
  logic [11:0] adx_r, ady_r;
  logic [12:0] dx, dy;
  assign dx = {1'b0, in_tdata[11:0]} - {1'b0, cx};
  assign dy = {1'b0, in_tdata[23:12]} - {1'b0, cy};

  // stage 2: squares
  logic        v2_r;
  logic [23:0] sqx_r, sqy_r;

  // stage 3: distance and disc test
  rfg_tag_t    tag3_r;
  logic [24:0] d2;
  assign d2 = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      tag3_r.valid <= 1'b0;
    end else if (adv) begin
      v1_r         <= in_tvalid;
      v2_r         <= v1_r;
      tag3_r.valid <= v2_r;
    end
    if (adv) begin
      adx_r          <= dx[12] ? 12'(-dx) : dx[11:0];
      ady_r          <= dy[12] ? 12'(-dy) : dy[11:0];
      sqx_r          <= 24'(adx_r) * 24'(adx_r);
      sqy_r          <= 24'(ady_r) * 24'(ady_r);
      tag3_r.in_disc <= (radius_r != 8'd0) && (d2 <= {9'd0, ss});
      tag3_r.d2      <= ((radius_r != 8'd0) && (d2 <= {9'd0, ss})) ? d2[15:0] : 16'd0;
    end
  end

  rfg_tag_t    tag_q;
  logic [15:0] root_q;

  rfg_sqrt_pipe u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tag_i  (tag3_r),
    .tag_o  (tag_q),
    .root_o (root_q)
  );

  // square of the lens difference and the linear numerator
  logic        vd_r;
  logic        ind_r;
  logic [31:0] dsq_r;
  logic [23:0] num0_r;
  logic [15:0] ldiff;
  logic [15:0] lin;
  assign ldiff = {radius_r, 8'd0} - root_q;
  assign lin   = ss - tag_q.d2;

  // numerator select
  logic        vn_r;
  logic        inn_r;
  logic [39:0] num_r;
  logic [31:0] den;
  assign den = mode_r ? {ss, 16'd0} : {16'd0, ss};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      vn_r <= 1'b0;
    end else if (adv) begin
      vd_r <= tag_q.valid;
      vn_r <= vd_r;
    end
    if (adv) begin
      ind_r  <= tag_q.in_disc;
      dsq_r  <= 32'(ldiff) * 32'(ldiff);
      num0_r <= {lin, 8'd0} - {8'd0, lin};
      inn_r  <= ind_r;
      num_r  <= mode_r ? ({dsq_r, 8'd0} - {8'd0, dsq_r}) : {16'd0, num0_r};
    end
  end

  // restoring divider, two quotient bits per stage
  logic        dv_s  [0:DIV_STAGES];
  logic        din_s [0:DIV_STAGES];
  logic [39:0] rem_s [0:DIV_STAGES];
  logic [7:0]  quo_s [0:DIV_STAGES];

  assign dv_s[0]  = vn_r;
  assign din_s[0] = inn_r;
  assign rem_s[0] = num_r;
  assign quo_s[0] = 8'd0;

  genvar k;
  generate
    for (k = 0; k < DIV_STAGES; k++) begin : g_div
      logic        dv_r, din_r;
      logic [39:0] rem_r, rem_nxt;
      logic [7:0]  quo_r, quo_nxt;
      logic [39:0] r_mid;
      logic [39:0] dhi, dlo;
      assign dhi = {8'd0, den} << (7 - 2*k);
      assign dlo = {8'd0, den} << (6 - 2*k);

      always_comb begin
        quo_nxt = quo_s[k];
        r_mid   = rem_s[k];
        if (r_mid >= dhi) begin
          r_mid             = r_mid - dhi;
          quo_nxt[7 - 2*k]  = 1'b1;
        end
        rem_nxt = r_mid;
        if (r_mid >= dlo) begin
          rem_nxt           = r_mid - dlo;
          quo_nxt[6 - 2*k]  = 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_r <= 1'b0;
        end else if (adv) begin
          dv_r <= dv_s[k];
        end
        if (adv) begin
          din_r <= din_s[k];
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
        end
      end

      assign dv_s[k+1]  = dv_r;
      assign din_s[k+1] = din_r;
      assign rem_s[k+1] = rem_r;
      assign quo_s[k+1] = quo_r;
    end
  endgenerate

  // output register
  logic [31:0] texel_r;
  logic [7:0]  chan;
  assign chan = din_s[DIV_STAGES] ? quo_s[DIV_STAGES] : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_s[DIV_STAGES];
    end
    if (adv) begin
      texel_r <= {mode_r ? chan : 8'hFF, chan, chan, chan};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = texel_r;

endmodule

### rtl/rfg_checker.sv
// Port-level checker for the texel generator, bound to the top level
`include "radial_falloff_texel_generator_core_defines.svh"

module rfg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  `RFG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out word dropped")
  `RFG_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "out word changed")
  `RFG_ASSERT_NOW(a_ready_free, !out_tvalid || out_tready, in_tready, "input stalled")
  `RFG_ASSERT_NOW(a_grey, out_tvalid, (out_tdata[7:0] == out_tdata[15:8]) && (out_tdata[15:8] == out_tdata[23:16]), "channels differ")

endmodule

bind radial_falloff_texel_generator_core rfg_checker u_rfg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/tb_radial_falloff_texel_generator_core.sv
// Self-checking stream testbench for the radial falloff texel generator
module tb_radial_falloff_texel_generator_core;
  import rfg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM_TB = 4096;
  localparam int DRAIN_CYCLES = 60;
  localparam longint CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // pixel_x [11:0], pixel_y [23:12]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // texel [31:0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  radial_falloff_texel_generator_core u_top (.*);

  // predictor copy of the registers
  logic        cur_mode;
  logic [7:0]  cur_radius;
  logic [12:0] cur_width;
  logic [12:0] cur_height;

  logic [23:0] pending_coords[$];
  logic [31:0] expected_texels[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;
  int          hold_cycles = 0;
  int          fail_count = 0;
  longint      cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint half_dim(logic [12:0] dim);
    longint d;
    d = (dim > MAX_DIM_TB) ? MAX_DIM_TB : dim;
    return d / 2;
  endfunction

  function automatic logic [31:0] predict_texel(logic [23:0] coord);
    longint dx;
    longint dy;
    longint unsigned d2;
    longint unsigned s;
    longint unsigned ss;
    longint unsigned diff;
    logic [7:0] c;
    bit in_disc;
    dx = longint'(coord[11:0]) - half_dim(cur_width);
    dy = longint'(coord[23:12]) - half_dim(cur_height);
    d2 = dx * dx + dy * dy;
    s = cur_radius;
    ss = s * s;
    in_disc = (s != 0) && (d2 <= ss);
    c = 8'd0;
    if (!cur_mode) begin
      if (in_disc) c = 8'((255 * (ss - d2)) / ss);
      return {8'hFF, c, c, c};
    end
    if (in_disc) begin
      diff = (s << 8) - isqrt(d2 << 16);
      c = 8'((255 * diff * diff) / (ss << 16));
    end
    return {c, c, c, c};
  endfunction

  // driver
  always @(posedge clk) begin
    logic [23:0] coord;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_coords.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        coord = pending_coords.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= coord;
        expected_texels.push_back(predict_texel(coord));
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_texels.size() == 0) begin
          $error("texel: unexpected word %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_texels.pop_front();
          if (want !== out_tdata) begin
            $error("texel: expected %h actual %h", want, out_tdata);
            fail_count++;
          end
        end
      end
      if (hold_off && hold_cycles < 200) begin
        hold_cycles++;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode   = val[0];
      REG_RADIUS: cur_radius = val[7:0];
      REG_WIDTH:  cur_width  = val[12:0];
      default:    cur_height = val[12:0];
    endcase
  endtask

  task automatic drain();
    while (pending_coords.size() != 0 || in_tvalid || expected_texels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random coordinate, mostly near the center so the disc gets hit
  function automatic logic [23:0] rand_coord();
    logic [11:0] x;
    logic [11:0] y;
    longint cx;
    longint cy;
    cx = half_dim(cur_width);
    cy = half_dim(cur_height);
    if ($urandom_range(9) < 8) begin
      x = 12'(cx + $signed($urandom_range(2 * 260)) - 260);
      y = 12'(cy + $signed($urandom_range(2 * 260)) - 260);
    end else begin
      x = 12'($urandom);
      y = 12'($urandom);
    end
    return {y, x};
  endfunction

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) pending_coords.push_back(rand_coord());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_mode = 1'b0;
    cur_radius = 8'd64;
    cur_width = 13'd256;
    cur_height = 13'd256;
    send_idle_pct = 36;
    recv_idle_pct = 84;
    hold_off = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, center, disc edge, field extremes
    pending_coords.push_back({12'd128, 12'd128});
    pending_coords.push_back({12'd128, 12'd192});
    pending_coords.push_back({12'd128, 12'd193});
    pending_coords.push_back({12'd0, 12'd0});
    pending_coords.push_back({12'hFFF, 12'hFFF});
    pending_coords.push_back({12'hAAA, 12'h555});
    pending_coords.push_back({12'h555, 12'hAAA});
    drain();
    write_reg(REG_MODE, 32'hFFFF_FFFF);
    pending_coords.push_back({12'd128, 12'd128});
    pending_coords.push_back({12'd150, 12'd100});
    pending_coords.push_back({12'd128, 12'd192});
    pending_coords.push_back({12'hFFF, 12'd0});
    drain();
    // zero radius: everything outside
    write_reg(REG_RADIUS, 32'h0);
    pending_coords.push_back({12'd128, 12'd128});
    drain();
    write_reg(REG_MODE, 32'h0);
    pending_coords.push_back({12'd128, 12'd128});
    drain();
    // oversized and zero dimensions, max radius
    write_reg(REG_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_WIDTH, 32'h1FFF);
    write_reg(REG_HEIGHT, 32'h0);
    pending_coords.push_back({12'd0, 12'd2048});
    pending_coords.push_back({12'd255, 12'd2048});
    pending_coords.push_back({12'd0, 12'd2300});
    drain();
    write_reg(REG_MODE, 32'h1);
    pending_coords.push_back({12'd0, 12'd2048});
    pending_coords.push_back({12'd100, 12'd2100});
    drain();
    write_reg(REG_WIDTH, 32'h1);
    write_reg(REG_HEIGHT, 32'd4096);
    pending_coords.push_back({12'd2048, 12'd0});
    drain();

    // back pressure: receiver stalls while sender keeps pushing
    hold_off = 1'b1;
    send_idle_pct = 0;
    run_phase(60);
    hold_off = 1'b0;

    for (int p = 0; p < 12; p++) begin
      send_idle_pct = (p < 4) ? 36 : (p < 8) ? 84 : 0;
      recv_idle_pct = (p < 4) ? 84 : (p < 8) ? 36 : 0;
      write_reg(REG_MODE, 32'($urandom_range(1)));
      case (p % 4)
        0: write_reg(REG_RADIUS, 32'd255);
        1: write_reg(REG_RADIUS, 32'd1);
        default: write_reg(REG_RADIUS, $urandom);
      endcase
      case (p % 3)
        0: write_reg(REG_WIDTH, 32'd4096);
        1: write_reg(REG_WIDTH, 32'd1);
        default: write_reg(REG_WIDTH, $urandom);
      endcase
      write_reg(REG_HEIGHT, (p % 5 == 0) ? 32'h1FFF : $urandom);
      run_phase(125);
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/rfg_pkg.sv
rtl/rfg_sqrt_pipe.sv
rtl/radial_falloff_texel_generator_core.sv
rtl/rfg_checker.sv
tb/tb_radial_falloff_texel_generator_core.sv
